// ----- rtl/bfi_pkg.sv -----
// Shared widths, constants and types for the buddy fragmentation index block.
package bfi_pkg;

    localparam int NUM_ORDERS = 11;
    localparam int CNT_W      = 32;
    localparam int QORD_W     = 4;
    localparam int PAGES_W    = 43;
    localparam int BLOCKS_W   = 36;
    localparam int UNUS_W     = 10;
    localparam int FRAG_W     = 11;
    localparam int NUM_W      = 53;
    localparam int QUO_W      = 11;
    localparam int SCALE      = 1000;

    typedef enum logic [1:0] {
        FRAG_ZERO,
        FRAG_FULL,
        FRAG_DIV
    } t_frag_sel;

endpackage

// ----- rtl/buddy_fragmentation_index_top.sv -----
// Top level: buddy allocator free-page sums and fragmentation scores.
//
//  channel | handshake          | payload
//  --------+--------------------+---------------------------------------------
//  input   | i_valid / o_stall  | i_free_count_o0..o10, i_query_order
//  output  | o_valid / i_stall  | o_total_free_pages, o_total_free_blocks,
//          |                    | o_suitable_blocks, o_unusable_index,
//          |                    | o_frag_index
//
// One beat per cycle while the output is not stalled; 3 sum/scale stages,
// 11 divider stages, then the output register. Divider depth sets most of the pipeline depth.
// Synchronous active-low reset clears the valid bits only.
// A stalled output freezes the whole pipeline; nothing is dropped.
module buddy_fragmentation_index_top #(
    parameter int TOP_ORDER  = 10,
    parameter int COUNT_BITS = 32
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_valid,
    output logic                      o_stall,
    input  logic [bfi_pkg::CNT_W-1:0] i_free_count_o0,
    input  logic [bfi_pkg::CNT_W-1:0] i_free_count_o1,
    input  logic [bfi_pkg::CNT_W-1:0] i_free_count_o2,
    input  logic [bfi_pkg::CNT_W-1:0] i_free_count_o3,
    input  logic [bfi_pkg::CNT_W-1:0] i_free_count_o4,
    input  logic [bfi_pkg::CNT_W-1:0] i_free_count_o5,
    input  logic [bfi_pkg::CNT_W-1:0] i_free_count_o6,
    input  logic [bfi_pkg::CNT_W-1:0] i_free_count_o7,
    input  logic [bfi_pkg::CNT_W-1:0] i_free_count_o8,
    input  logic [bfi_pkg::CNT_W-1:0] i_free_count_o9,
    input  logic [bfi_pkg::CNT_W-1:0] i_free_count_o10,
    input  logic [bfi_pkg::QORD_W-1:0] i_query_order,
    output logic                      o_valid,
    input  logic                      i_stall,
    output logic [bfi_pkg::PAGES_W-1:0]  o_total_free_pages,
    output logic [bfi_pkg::BLOCKS_W-1:0] o_total_free_blocks,
    output logic [bfi_pkg::PAGES_W-1:0]  o_suitable_blocks,
    output logic [bfi_pkg::UNUS_W-1:0]   o_unusable_index,
    output logic signed [bfi_pkg::FRAG_W-1:0] o_frag_index
);
    import bfi_pkg::*;

    localparam int CW = (COUNT_BITS < CNT_W) ? COUNT_BITS : CNT_W;
    localparam logic [CNT_W-1:0] CMASK = CNT_W'((64'(1) << CW) - 64'(1));
    localparam int NG = TOP_ORDER / 4 + 1;
    localparam int DQ = QUO_W;

    logic ce;
    logic [CNT_W-1:0] cnt [NUM_ORDERS];

    assign cnt[0]  = i_free_count_o0;
    assign cnt[1]  = i_free_count_o1;
    assign cnt[2]  = i_free_count_o2;
    assign cnt[3]  = i_free_count_o3;
    assign cnt[4]  = i_free_count_o4;
    assign cnt[5]  = i_free_count_o5;
    assign cnt[6]  = i_free_count_o6;
    assign cnt[7]  = i_free_count_o7;
    assign cnt[8]  = i_free_count_o8;
    assign cnt[9]  = i_free_count_o9;
    assign cnt[10] = i_free_count_o10;

    assign ce      = !(o_valid && i_stall);
    assign o_stall = !ce;

    // stage 1: group sums
    logic [PAGES_W-1:0]  n_a_pg [NG];
    logic [BLOCKS_W-1:0] n_a_bk [NG];
    logic [PAGES_W-1:0]  n_a_sp [NG];
    logic [PAGES_W-1:0]  r_a_pg [NG];
    logic [BLOCKS_W-1:0] r_a_bk [NG];
    logic [PAGES_W-1:0]  r_a_sp [NG];
    logic [QORD_W-1:0]   r_a_q;
    logic                r_a_v;

    always_comb begin
        logic [PAGES_W-1:0] c;
        for (int g = 0; g < NG; g++) begin
            n_a_pg[g] = '0;
            n_a_bk[g] = '0;
            n_a_sp[g] = '0;
        end
        for (int k = 0; k <= TOP_ORDER; k++) begin
            c = PAGES_W'(cnt[k] & CMASK);
            n_a_pg[k/4] = n_a_pg[k/4] + (c << k);
            n_a_bk[k/4] = n_a_bk[k/4] + BLOCKS_W'(cnt[k] & CMASK);
            if (k >= int'(i_query_order)) begin
                n_a_sp[k/4] = n_a_sp[k/4] + (c << k);
            end
        end
    end

    // stage 2: totals
    logic [PAGES_W-1:0]  n_b_pages, r_b_pages;
    logic [BLOCKS_W-1:0] n_b_blocks, r_b_blocks;
    logic [PAGES_W-1:0]  n_b_sp, r_b_sp;
    logic [QORD_W-1:0]   r_b_q;
    logic                r_b_v;

    always_comb begin
        n_b_pages  = '0;
        n_b_blocks = '0;
        n_b_sp     = '0;
        for (int g = 0; g < NG; g++) begin
            n_b_pages  = n_b_pages + r_a_pg[g];
            n_b_blocks = n_b_blocks + r_a_bk[g];
            n_b_sp     = n_b_sp + r_a_sp[g];
        end
    end

    // stage 3: scaled numerators, special-case flags
    logic [NUM_W-1:0]    n_c_unum, r_c_unum;
    logic [NUM_W-1:0]    n_c_fnum, r_c_fnum;
    logic [PAGES_W-1:0]  n_c_suit, r_c_suit;
    t_frag_sel           n_c_sel, r_c_sel;
    logic [PAGES_W-1:0]  r_c_pages;
    logic [BLOCKS_W-1:0] r_c_blocks;
    logic                r_c_v;

    always_comb begin
        n_c_unum = NUM_W'(r_b_pages - r_b_sp) * NUM_W'(SCALE);
        n_c_fnum = ((NUM_W'(r_b_pages) * NUM_W'(SCALE)) >> r_b_q) + NUM_W'(SCALE);
        n_c_suit = r_b_sp >> r_b_q;
        if (int'(r_b_q) > TOP_ORDER || r_b_blocks == '0) begin
            n_c_sel = FRAG_ZERO;
        end else if (r_b_sp != '0) begin
            n_c_sel = FRAG_FULL;
        end else begin
            n_c_sel = FRAG_DIV;
        end
    end

    always_ff @(posedge i_clk) begin
        if (ce) begin
            for (int g = 0; g < NG; g++) begin
                r_a_pg[g] <= n_a_pg[g];
                r_a_bk[g] <= n_a_bk[g];
                r_a_sp[g] <= n_a_sp[g];
            end
            r_a_q      <= i_query_order;
            r_b_pages  <= n_b_pages;
            r_b_blocks <= n_b_blocks;
            r_b_sp     <= n_b_sp;
            r_b_q      <= r_a_q;
            r_c_unum   <= n_c_unum;
            r_c_fnum   <= n_c_fnum;
            r_c_suit   <= n_c_suit;
            r_c_sel    <= n_c_sel;
            r_c_pages  <= r_b_pages;
            r_c_blocks <= r_b_blocks;
        end
    end

    // dividers
    logic [QUO_W-1:0] quo_u, quo_f;

    bfi_div #(.NW(NUM_W), .DW(PAGES_W), .QB(QUO_W)) u_div_unus (
        .i_clk (i_clk),
        .i_ce  (ce),
        .i_num (r_c_unum),
        .i_den (r_c_pages),
        .o_quo (quo_u)
    );

    bfi_div #(.NW(NUM_W), .DW(BLOCKS_W), .QB(QUO_W)) u_div_frag (
        .i_clk (i_clk),
        .i_ce  (ce),
        .i_num (r_c_fnum),
        .i_den (r_c_blocks),
        .o_quo (quo_f)
    );

    // side data alongside the dividers
    logic [PAGES_W-1:0]  r_d_pages  [DQ];
    logic [BLOCKS_W-1:0] r_d_blocks [DQ];
    logic [PAGES_W-1:0]  r_d_suit   [DQ];
    t_frag_sel           r_d_sel    [DQ];
    logic [DQ-1:0]       r_d_v;

    always_ff @(posedge i_clk) begin
        if (ce) begin
            r_d_pages[0]  <= r_c_pages;
            r_d_blocks[0] <= r_c_blocks;
            r_d_suit[0]   <= r_c_suit;
            r_d_sel[0]    <= r_c_sel;
            for (int i = 1; i < DQ; i++) begin
                r_d_pages[i]  <= r_d_pages[i-1];
                r_d_blocks[i] <= r_d_blocks[i-1];
                r_d_suit[i]   <= r_d_suit[i-1];
                r_d_sel[i]    <= r_d_sel[i-1];
            end
        end
    end

    // output register
    logic [UNUS_W-1:0]        n_o_unus, r_o_unus;
    logic [FRAG_W-1:0]        n_o_frag, r_o_frag;
    logic [PAGES_W-1:0]       r_o_pages, r_o_suit;
    logic [BLOCKS_W-1:0]      r_o_blocks;
    logic                     r_o_v;

    always_comb begin
        n_o_unus = (r_d_pages[DQ-1] == '0) ? UNUS_W'(SCALE) : quo_u[UNUS_W-1:0];
        case (r_d_sel[DQ-1])
            FRAG_ZERO: n_o_frag = '0;
            FRAG_FULL: n_o_frag = FRAG_W'(-SCALE);
            FRAG_DIV:  n_o_frag = FRAG_W'(SCALE) - FRAG_W'(quo_f);
            default:   n_o_frag = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (ce) begin
            r_o_pages  <= r_d_pages[DQ-1];
            r_o_blocks <= r_d_blocks[DQ-1];
            r_o_suit   <= r_d_suit[DQ-1];
            r_o_unus   <= n_o_unus;
            r_o_frag   <= n_o_frag;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_v <= 1'b0;
            r_b_v <= 1'b0;
            r_c_v <= 1'b0;
            r_d_v <= '0;
            r_o_v <= 1'b0;
        end else if (ce) begin
            r_a_v <= i_valid;
            r_b_v <= r_a_v;
            r_c_v <= r_b_v;
            r_d_v <= {r_d_v[DQ-2:0], r_c_v};
            r_o_v <= r_d_v[DQ-1];
        end
    end

    assign o_valid             = r_o_v;
    assign o_total_free_pages  = r_o_pages;
    assign o_total_free_blocks = r_o_blocks;
    assign o_suitable_blocks   = r_o_suit;
    assign o_unusable_index    = r_o_unus;
    assign o_frag_index        = r_o_frag;

endmodule

// ----- rtl/bfi_div.sv -----
// Pipelined restoring divider, one quotient bit per stage.
module bfi_div #(
    parameter int NW = 53,
    parameter int DW = 43,
    parameter int QB = 11
) (
    input  logic          i_clk,
    input  logic          i_ce,
    input  logic [NW-1:0] i_num,
    input  logic [DW-1:0] i_den,
    output logic [QB-1:0] o_quo
);

    logic [NW-1:0] r_rem [QB];
    logic [DW-1:0] r_den [QB];
    logic [QB-1:0] r_quo [QB];
    logic [NW-1:0] n_rem [QB];
    logic [QB-1:0] n_quo [QB];

    // {quotient bit, remainder after trial subtract}
    function automatic logic [NW:0] div_step(input logic [NW-1:0] rem,
                                             input logic [DW-1:0] den,
                                             input int            sh);
        logic [NW+QB-1:0] trial;
        logic             ge;
        trial = (NW+QB)'(den) << sh;
        ge    = ((NW+QB)'(rem) >= trial);
        return {ge, ge ? (rem - trial[NW-1:0]) : rem};
    endfunction

    always_comb begin
        logic [NW:0] s;
        s        = div_step(i_num, i_den, QB - 1);
        n_rem[0] = s[NW-1:0];
        n_quo[0] = QB'(s[NW]);
        for (int i = 1; i < QB; i++) begin
            s        = div_step(r_rem[i-1], r_den[i-1], QB - 1 - i);
            n_rem[i] = s[NW-1:0];
            n_quo[i] = {r_quo[i-1][QB-2:0], s[NW]};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ce) begin
            r_den[0] <= i_den;
            for (int i = 1; i < QB; i++) begin
                r_den[i] <= r_den[i-1];
            end
            for (int i = 0; i < QB; i++) begin
                r_rem[i] <= n_rem[i];
                r_quo[i] <= n_quo[i];
            end
        end
    end

    assign o_quo = r_quo[QB-1];

endmodule
